// ===== design/shp_pkg.sv =====
// Shared types and constants for the staged heater PID controller.
// Used by the interfaces, sequencer, datapath and top; depends on nothing.
`default_nettype none
package shp_pkg;

	// field widths
	localparam int TEMP_W  = 12;
	localparam int SP_W    = 11;
	localparam int BAND_W  = 8;
	localparam int GAIN_W  = 16;
	localparam int POWER_W = 7;
	localparam int STAGE_W = 2;
	localparam int ERR_W   = 13;
	localparam int ACC_W   = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// window depth default
	localparam int WINDOW_DEPTH_DEF = 8;

	// integral clamp numerator: 100 percent in 1/4096 percent units
	localparam int LIM_W = 19;
	localparam logic [LIM_W-1:0] LIM_NUM = 19'd409600;

	// stage codes
	localparam logic [STAGE_W-1:0] STAGE_PREHEAT  = 2'd0;
	localparam logic [STAGE_W-1:0] STAGE_APPROACH = 2'd1;
	localparam logic [STAGE_W-1:0] STAGE_PID      = 2'd2;
	localparam logic [STAGE_W-1:0] STAGE_FAULT    = 2'd3;

	// power levels
	localparam logic [POWER_W-1:0] PWR_FULL = 7'd100;
	localparam logic [POWER_W-1:0] PWR_HIGH = 7'd60;
	localparam logic [POWER_W-1:0] PWR_LOW  = 7'd40;
	localparam logic [POWER_W-1:0] PWR_OFF  = 7'd0;

	// approach threshold offset, 2 degrees
	localparam logic signed [ERR_W-1:0] APPROACH_OFS = 13'sd32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOST      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIP      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PREHEAT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BAND      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd7;

	// register reset values
	localparam logic [SP_W-1:0]          RST_SETPOINT = 11'd592;
	localparam logic signed [TEMP_W-1:0] RST_LOST     = 12'sd80;
	localparam logic [SP_W-1:0]          RST_TRIP     = 11'd640;
	localparam logic [SP_W-1:0]          RST_PREHEAT  = 11'd512;
	localparam logic [BAND_W-1:0]        RST_BAND     = 8'd2;
	localparam logic [GAIN_W-1:0]        RST_GAIN_P   = 16'd7680;
	localparam logic [GAIN_W-1:0]        RST_GAIN_I   = 16'd256;
	localparam logic [GAIN_W-1:0]        RST_GAIN_D   = 16'd1280;

	// controller to datapath commands
	typedef struct packed {
		logic in_ready;
		logic eval;
		logic scan_step;
		logic scan_fin;
		logic div_step;
		logic acc;
		logic mul_step;
		logic pid_fin;
		logic load_out;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic                in_valid;
		logic                need_scan;
		logic                need_pid;
		logic                scan_done;
		logic                div_done;
		logic                mul_done;
		logic                out_free;
		logic [STAGE_W-1:0]  stage;
	} sts_t;

endpackage
`default_nettype wire

// ===== design/shp_if.sv =====
// Channel interfaces for samples and results of the heater controller.
// Depends on shp_pkg for field widths.
`default_nettype none
interface shp_sample_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [shp_pkg::TEMP_W-1:0]     temperature;
	logic                                  out_of_range;

	modport source (output valid, output temperature, output out_of_range, input ready);
	modport sink (input valid, input temperature, input out_of_range, output ready);
endinterface

interface shp_result_if;
	logic                            valid;
	logic                            ready;
	logic [shp_pkg::POWER_W-1:0]     heat_pct;
	logic [shp_pkg::STAGE_W-1:0]     stage;
	logic                            sensor_lost;

	modport source (output valid, output heat_pct, output stage, output sensor_lost,
		input ready);
	modport sink (input valid, input heat_pct, input stage, input sensor_lost,
		output ready);
endinterface
`default_nettype wire

// ===== design/shp_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module shp_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== design/shp_ctrl.sv =====
// Sequencer of the heater controller: steps the datapath through one sample.
// Depends on shp_pkg for the command and status types.
`default_nettype none
module shp_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire shp_pkg::sts_t  sts,
	output      shp_pkg::cmd_t  cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVAL = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_ACC  = 3'd4;
	localparam logic [2:0] S_MUL  = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;
	localparam logic [2:0] S_OUT  = 3'd7;

	logic [2:0] state_q, state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.in_valid) state_d = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				if (sts.need_scan) state_d = S_SCAN;
				else if (sts.need_pid) state_d = S_DIV;
				else state_d = S_OUT;
			end
			S_SCAN: begin
				if (sts.scan_done) begin
					cmd.scan_fin = 1'b1;
					state_d = S_OUT;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_DIV: begin
				if (sts.div_done) state_d = S_ACC;
				else cmd.div_step = 1'b1;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				if (sts.mul_done) state_d = S_FIN;
				else cmd.mul_step = 1'b1;
			end
			S_FIN: begin
				cmd.pid_fin = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

// ===== design/shp_dp.sv =====
// Datapath of the heater controller: registers, window RAM, min/max scan,
// clamp divider, shared multiplier and the result register.
// Depends on shp_pkg, shp_if and shp_ram.
`default_nettype none
module shp_dp #(
	parameter int WINDOW_DEPTH = shp_pkg::WINDOW_DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [shp_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire logic [shp_pkg::CFG_DATA_W-1:0]    cfg_data,
	shp_sample_if.sink                             sample,
	shp_result_if.source                           result,
	input  wire shp_pkg::cmd_t                     cmd,
	output      shp_pkg::sts_t                     sts
);
	localparam int AW  = $clog2(WINDOW_DEPTH);
	localparam int CW  = $clog2(WINDOW_DEPTH + 1);
	localparam int TW  = shp_pkg::TEMP_W;
	localparam int EW  = shp_pkg::ERR_W;
	localparam int GW  = shp_pkg::GAIN_W;
	localparam int LW  = shp_pkg::LIM_W;
	localparam int AOW = 21;              // integral operand, |acc| <= 409600 when the I gain is nonzero
	localparam int PW  = GW + 1 + AOW;    // product width
	localparam int SW  = PW + 2;          // sum of three products
	localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);
	localparam logic [CW-1:0] DEPTH_M1 = CW'(WINDOW_DEPTH - 1);
	localparam logic [4:0] DIV_STEPS = 5'(LW);

	// configuration registers
	logic [shp_pkg::SP_W-1:0]    setpoint_q, trip_q, preheat_q;
	logic signed [TW-1:0]        lost_q;
	logic [shp_pkg::BAND_W-1:0]  band_q;
	logic [GW-1:0]               gain_p_q, gain_i_q, gain_d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= shp_pkg::RST_SETPOINT;
			lost_q     <= shp_pkg::RST_LOST;
			trip_q     <= shp_pkg::RST_TRIP;
			preheat_q  <= shp_pkg::RST_PREHEAT;
			band_q     <= shp_pkg::RST_BAND;
			gain_p_q   <= shp_pkg::RST_GAIN_P;
			gain_i_q   <= shp_pkg::RST_GAIN_I;
			gain_d_q   <= shp_pkg::RST_GAIN_D;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				shp_pkg::CFG_SETPOINT: setpoint_q <= cfg_data[shp_pkg::SP_W-1:0];
				shp_pkg::CFG_LOST:     lost_q     <= cfg_data[TW-1:0];
				shp_pkg::CFG_TRIP:     trip_q     <= cfg_data[shp_pkg::SP_W-1:0];
				shp_pkg::CFG_PREHEAT:  preheat_q  <= cfg_data[shp_pkg::SP_W-1:0];
				shp_pkg::CFG_BAND:     band_q     <= cfg_data[shp_pkg::BAND_W-1:0];
				shp_pkg::CFG_GAIN_P:   gain_p_q   <= cfg_data;
				shp_pkg::CFG_GAIN_I:   gain_i_q   <= cfg_data;
				shp_pkg::CFG_GAIN_D:   gain_d_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// captured sample
	logic signed [TW-1:0] t_q;
	logic                 oor_q;
	logic                 capture;

	assign capture      = sample.valid && cmd.in_ready;
	assign sample.ready = cmd.in_ready;

	always_ff @(posedge clk) begin
		if (capture) begin
			t_q   <= sample.temperature;
			oor_q <= sample.out_of_range;
		end
	end

	// sample classification
	logic signed [EW-1:0] t_x, sp_x, err;
	logic lost, trip, approach_low, reach_pre, latched, accept_win;
	logic [shp_pkg::STAGE_W-1:0] stage_q;

	assign t_x          = EW'(t_q);
	assign sp_x         = $signed({2'b00, setpoint_q});
	assign err          = sp_x - t_x;
	assign lost         = t_q <= lost_q;
	assign trip         = oor_q || (t_x > $signed({2'b00, trip_q}));
	assign approach_low = t_x < (sp_x - shp_pkg::APPROACH_OFS);
	assign reach_pre    = t_x >= $signed({2'b00, preheat_q});
	assign latched      = stage_q == shp_pkg::STAGE_FAULT;
	assign accept_win   = !lost && !latched && !trip;

	// window state
	logic [AW-1:0] pos_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] scan_cnt_q;
	logic          rd_v_q, first_q;
	logic signed [TW-1:0] rdata, lo_q, hi_q;
	logic signed [EW-1:0] span;
	logic          win_we;

	assign win_we = cmd.eval && accept_win;
	assign span   = EW'(hi_q) - EW'(lo_q);

	shp_ram #(.WIDTH(TW), .DEPTH(WINDOW_DEPTH)) u_window (
		.clk   (clk),
		.we    (win_we),
		.waddr (pos_q),
		.wdata (t_q),
		.raddr (scan_cnt_q[AW-1:0]),
		.rdata (rdata)
	);

	// divider, integral and multiply state
	logic [LW-1:0]  dvd_q, quo_q;
	logic [GW:0]    rem_q, rem_sh;
	logic [4:0]     div_cnt_q;
	logic signed [shp_pkg::ACC_W-1:0] integ_q;
	logic signed [EW-1:0] last_err_q;
	logic [2:0]     mcnt_q;
	logic signed [PW-1:0] prod_q;
	logic signed [SW-1:0] sum_q;
	logic signed [GW:0]   mul_a;
	logic signed [AOW-1:0] mul_b;
	logic signed [shp_pkg::ACC_W:0] acc_wide;
	logic signed [shp_pkg::ACC_W-1:0] acc_sat, acc_clamp, lim_x;
	logic signed [EW:0] derr;
	logic [shp_pkg::POWER_W-1:0] res_power_q, pid_power;
	logic res_lost_q;

	assign rem_sh = {rem_q[GW-1:0], dvd_q[LW-1]};

	// saturate, then clamp the integral sum
	always_comb begin
		acc_wide = (shp_pkg::ACC_W+1)'(integ_q) + (shp_pkg::ACC_W+1)'(err);
		lim_x    = $signed({{(shp_pkg::ACC_W-LW){1'b0}}, quo_q});
		if (acc_wide[shp_pkg::ACC_W] != acc_wide[shp_pkg::ACC_W-1]) begin
			acc_sat = acc_wide[shp_pkg::ACC_W] ? {1'b1, {(shp_pkg::ACC_W-1){1'b0}}}
				: {1'b0, {(shp_pkg::ACC_W-1){1'b1}}};
		end else begin
			acc_sat = acc_wide[shp_pkg::ACC_W-1:0];
		end
		acc_clamp = acc_sat;
		if (gain_i_q != '0) begin
			if (acc_sat > lim_x) acc_clamp = lim_x;
			else if (acc_sat < -lim_x) acc_clamp = -lim_x;
		end
	end

	// shared multiplier operand select
	assign derr = (EW+1)'(err) - (EW+1)'(last_err_q);
	always_comb begin
		unique case (mcnt_q[1:0])
			2'd0: begin
				mul_a = $signed({1'b0, gain_p_q});
				mul_b = AOW'(err);
			end
			2'd1: begin
				mul_a = $signed({1'b0, gain_i_q});
				mul_b = integ_q[AOW-1:0];
			end
			2'd2: begin
				mul_a = $signed({1'b0, gain_d_q});
				mul_b = AOW'(derr);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// output scaling and clamp
	always_comb begin
		if (sum_q <= 0) pid_power = shp_pkg::PWR_OFF;
		else if (sum_q >= SW'($signed({1'b0, shp_pkg::LIM_NUM}))) pid_power = shp_pkg::PWR_FULL;
		else pid_power = sum_q[shp_pkg::POWER_W+11:12];
	end

	// control state of the sample sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q    <= shp_pkg::STAGE_PREHEAT;
			pos_q      <= '0;
			fill_q     <= '0;
			integ_q    <= '0;
			last_err_q <= '0;
			scan_cnt_q <= '0;
			rd_v_q     <= 1'b0;
			first_q    <= 1'b0;
			div_cnt_q  <= '0;
			mcnt_q     <= '0;
		end else begin
			if (cmd.eval) begin
				scan_cnt_q <= '0;
				rd_v_q     <= 1'b0;
				first_q    <= 1'b1;
				div_cnt_q  <= '0;
				if (!lost && !latched) begin
					if (trip) begin
						stage_q <= shp_pkg::STAGE_FAULT;
					end else begin
						pos_q <= (pos_q == AW'(WINDOW_DEPTH - 1)) ? '0 : pos_q + 1'b1;
						if (fill_q != DEPTH_C) fill_q <= fill_q + 1'b1;
						if (stage_q == shp_pkg::STAGE_PREHEAT && reach_pre) begin
							stage_q <= shp_pkg::STAGE_APPROACH;
						end
					end
				end
			end
			if (cmd.scan_step) begin
				rd_v_q <= scan_cnt_q != DEPTH_C;
				if (scan_cnt_q != DEPTH_C) scan_cnt_q <= scan_cnt_q + 1'b1;
				if (rd_v_q) first_q <= 1'b0;
			end
			if (cmd.scan_fin && span <= $signed({5'b0, band_q})) begin
				stage_q    <= shp_pkg::STAGE_PID;
				integ_q    <= '0;
				last_err_q <= err;
			end
			if (cmd.div_step) div_cnt_q <= div_cnt_q + 1'b1;
			if (cmd.acc) begin
				integ_q <= acc_clamp;
				mcnt_q  <= '0;
			end
			if (cmd.mul_step) mcnt_q <= mcnt_q + 1'b1;
			if (cmd.pid_fin) last_err_q <= err;
		end
	end

	// window min and max fold
	always_ff @(posedge clk) begin
		if (cmd.scan_step && rd_v_q) begin
			if (first_q) begin
				lo_q <= rdata;
				hi_q <= rdata;
			end else begin
				if (rdata < lo_q) lo_q <= rdata;
				if (rdata > hi_q) hi_q <= rdata;
			end
		end
	end

	// restoring divider for the integral clamp, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			dvd_q <= shp_pkg::LIM_NUM;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[LW-2:0], 1'b0};
			if (rem_sh >= {1'b0, gain_i_q}) begin
				rem_q <= rem_sh - {1'b0, gain_i_q};
				quo_q <= {quo_q[LW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[LW-2:0], 1'b0};
			end
		end
	end

	// multiply then accumulate, register between the two
	always_ff @(posedge clk) begin
		if (cmd.acc) begin
			prod_q <= '0;
			sum_q  <= '0;
		end else if (cmd.mul_step) begin
			prod_q <= PW'(mul_a * mul_b);
			sum_q  <= sum_q + SW'(prod_q);
		end
	end

	// result of this sample
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			res_lost_q <= lost;
			if (lost || latched || trip) res_power_q <= shp_pkg::PWR_OFF;
			else if (stage_q == shp_pkg::STAGE_PREHEAT) res_power_q <= shp_pkg::PWR_FULL;
			else if (approach_low) res_power_q <= shp_pkg::PWR_HIGH;
			else res_power_q <= shp_pkg::PWR_LOW;
		end else if (cmd.pid_fin) begin
			res_power_q <= pid_power;
		end
	end

	// output register
	logic out_valid_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			result.heat_pct    <= res_power_q;
			result.stage       <= stage_q;
			result.sensor_lost <= res_lost_q;
		end
	end
	assign result.valid = out_valid_q;

	// status to the sequencer
	always_comb begin
		sts.in_valid  = sample.valid;
		sts.need_scan = accept_win && stage_q == shp_pkg::STAGE_APPROACH && !approach_low
			&& fill_q >= DEPTH_M1;
		sts.need_pid  = accept_win && stage_q == shp_pkg::STAGE_PID;
		sts.scan_done = scan_cnt_q == DEPTH_C && !rd_v_q;
		sts.div_done  = div_cnt_q == DIV_STEPS;
		sts.mul_done  = mcnt_q == 3'd4;
		sts.out_free  = !out_valid_q || result.ready;
		sts.stage     = stage_q;
	end
endmodule
`default_nettype wire

// ===== design/staged_heater_pid_controller_top.sv =====
// Staged heater PID controller, top level.
// Takes one temperature sample on the sample channel and returns one
// transaction on the result channel: power in percent, stage, sensor lost.
// The user writes configuration registers via cfg_we/cfg_idx/cfg_data only while
// idle; the block does not enforce this. Writes land at once, no read-back.
// One sample is taken at a time. Steps from sample accept to result valid:
//   sensor lost, error or trip, preheat, approach without scan: evaluate, output
//   approach with window scan: evaluate, scan (one RAM read a cycle), output
//   PID: evaluate, clamp divider, integral update, shared multiplier, output
// The next sample is accepted the cycle after the result is loaded, so one
// result can wait in the output register while the next sample is worked on.
// If the receiver stalls, the finished result waits for the output register.
// Reset (arst_n low) returns registers to defaults, stage to preheat,
// and empties the window; nothing is pending after reset.
// Depends on shp_pkg, shp_if, shp_ram, shp_ctrl and shp_dp.
`default_nettype none
module staged_heater_pid_controller_top #(
	parameter int WINDOW_DEPTH = shp_pkg::WINDOW_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [shp_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [shp_pkg::CFG_DATA_W-1:0] cfg_data,
	shp_sample_if.sink                          sample,
	shp_result_if.source                        result
);
	shp_pkg::cmd_t cmd;
	shp_pkg::sts_t sts;

	shp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	shp_dp #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.sample   (sample),
		.result   (result),
		.cmd      (cmd),
		.sts      (sts)
	);

	// one sample in flight at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> !sample.ready)
		else $error("second sample accepted while busy");

	// error stage is left only by reset
	a_err_latch: assert property (@(posedge clk) disable iff (!arst_n)
		sts.stage == shp_pkg::STAGE_FAULT |=> sts.stage == shp_pkg::STAGE_FAULT)
		else $error("error stage left without reset");

	// power stays within 0..100
	a_power_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.heat_pct <= shp_pkg::PWR_FULL)
		else $error("power above 100 percent");

	// lost sensor drives no power
	a_lost_off: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.sensor_lost |-> result.heat_pct == shp_pkg::PWR_OFF)
		else $error("power nonzero with sensor lost");
endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Testbench for the staged heater PID controller: directed and random samples,
// checked against an in-bench model of the stage machine and the PID math.
// Depends on shp_pkg, shp_if and staged_heater_pid_controller_top.
`timescale 1ns / 1ps
module tb;
	import shp_pkg::*;

	localparam int IDLE_LIMIT  = 4000;
	localparam int SETTLE_CYC  = 40;
	localparam int WIN_DEPTH   = 8;

	typedef struct {
		logic [POWER_W-1:0] power;
		logic [STAGE_W-1:0] stage;
		logic               lost;
	} heat_out_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	shp_sample_if smp ();
	shp_result_if res ();

	staged_heater_pid_controller_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.sample  (smp),
		.result  (res)
	);

	// controller registers as seen by the bench
	int unsigned sp_val, trip_val, preheat_val, band_val, kp, ki, kd;
	int          lost_val;

	// controller state
	logic [STAGE_W-1:0] cur_stage;
	int                 win [WIN_DEPTH];
	int unsigned        win_pos, win_fill;
	int                 integ;
	int                 prev_err;

	heat_out_t power_q[$];
	int        error_count;
	bit        quiet;
	int        hold_req;

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic report(input string what);
		$display("tb: mismatch: %s", what);
		error_count++;
	endtask

	function automatic bit window_is_flat();
		int lo, hi;
		if (win_fill < WIN_DEPTH)
			return 1'b0;
		lo = win[0];
		hi = win[0];
		for (int i = 1; i < WIN_DEPTH; i++) begin
			if (win[i] < lo) lo = win[i];
			if (win[i] > hi) hi = win[i];
		end
		return (hi - lo) <= int'(band_val);
	endfunction

	function automatic logic [POWER_W-1:0] pid_drive(input int e);
		longint acc, lim, sum;
		acc = longint'(integ) + e;
		if (acc > 64'sd2147483647) acc = 64'sd2147483647;
		if (acc < -64'sd2147483648) acc = -64'sd2147483648;
		if (ki != 0) begin
			lim = 409600 / ki;
			if (acc > lim) acc = lim;
			if (acc < -lim) acc = -lim;
		end
		integ = int'(acc);
		sum = longint'(kp) * e + longint'(ki) * acc + longint'(kd) * (longint'(e) - prev_err);
		prev_err = e;
		if (sum <= 0) return PWR_OFF;
		if (sum >= 409600) return PWR_FULL;
		return POWER_W'(sum / 4096);
	endfunction

	// next heater command for one sample; updates the bench state
	function automatic heat_out_t heater_response(input logic signed [TEMP_W-1:0] temp,
		input logic oor);
		heat_out_t r;
		int t, e;
		t = int'(temp);
		e = int'(sp_val) - t;
		r.power = PWR_OFF;
		r.lost  = 1'b0;
		if (t <= lost_val) begin
			r.stage = cur_stage;
			r.lost  = 1'b1;
			return r;
		end
		if (cur_stage != STAGE_FAULT) begin
			if (oor || t > int'(trip_val)) begin
				cur_stage = STAGE_FAULT;
			end else begin
				win[win_pos] = t;
				win_pos = (win_pos + 1) % WIN_DEPTH;
				if (win_fill < WIN_DEPTH) win_fill++;
				case (cur_stage)
					STAGE_PREHEAT: begin
						r.power = PWR_FULL;
						if (t >= int'(preheat_val)) cur_stage = STAGE_APPROACH;
					end
					STAGE_APPROACH: begin
						if (t < int'(sp_val) - 32) begin
							r.power = PWR_HIGH;
						end else begin
							r.power = PWR_LOW;
							if (window_is_flat()) begin
								cur_stage = STAGE_PID;
								integ = 0;
								prev_err = e;
							end
						end
					end
					default: r.power = pid_drive(e);
				endcase
			end
		end
		r.stage = cur_stage;
		return r;
	endfunction

	// register write; upper bits carry junk that the block must drop
	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		logic [CFG_DATA_W-1:0] d;
		d = CFG_DATA_W'($urandom);
		case (idx)
			CFG_SETPOINT: begin d[SP_W-1:0] = value; sp_val = d[SP_W-1:0]; end
			CFG_LOST: begin
				d[TEMP_W-1:0] = value;
				lost_val = int'($signed(d[TEMP_W-1:0]));
			end
			CFG_TRIP: begin d[SP_W-1:0] = value; trip_val = d[SP_W-1:0]; end
			CFG_PREHEAT: begin d[SP_W-1:0] = value; preheat_val = d[SP_W-1:0]; end
			CFG_BAND: begin d[BAND_W-1:0] = value; band_val = d[BAND_W-1:0]; end
			CFG_GAIN_P: begin d = value; kp = d; end
			CFG_GAIN_I: begin d = value; ki = d; end
			default: begin d = value; kd = d; end
		endcase
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= d;
		@(posedge clk);
	endtask

	task automatic end_writes();
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// wait until every result has come, then let the block settle
	task automatic drain_results();
		smp.valid <= 1'b0;
		while (power_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic send_sample(input int temp, input logic oor);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			smp.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp.valid        <= 1'b1;
		smp.temperature  <= TEMP_W'(temp);
		smp.out_of_range <= oor;
		do @(posedge clk); while (!smp.ready);
		power_q.push_back(heater_response(TEMP_W'(temp), oor));
	endtask

	function automatic int pick(input int lo, input int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	// n samples near setpoint, now and then one at or below the lost threshold
	task automatic pid_burst(input int n, input int spread);
		int lo, hi, t;
		lo = lost_val + 1;
		hi = int'(trip_val);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0 && lost_val >= -2048)
				t = pick(-2048, lost_val);
			else begin
				t = int'(sp_val) + pick(-spread, spread);
				if (t < lo) t = lo;
				if (t > hi) t = hi;
			end
			send_sample(t, 1'b0);
		end
	endtask

	// result side: stalls, long hold-off and checking
	initial begin
		int stall_left, hold_left;
		heat_out_t want;
		stall_left = 0;
		hold_left = 0;
		res.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (res.valid && res.ready) begin
				if (power_q.size() == 0) begin
					report("result with nothing expected");
				end else begin
					want = power_q.pop_front();
					if (res.heat_pct !== want.power)
						report($sformatf("power %0d, want %0d", res.heat_pct, want.power));
					if (res.stage !== want.stage)
						report($sformatf("stage %0d, want %0d", res.stage, want.stage));
					if (res.sensor_lost !== want.lost)
						report($sformatf("sensor_lost %b, want %b", res.sensor_lost, want.lost));
				end
				stall_left = quiet ? 0 : $urandom_range(0, 4);
			end
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transaction
	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((smp.valid && smp.ready) || (res.valid && res.ready))
				idle = 0;
			else
				idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("tb: done, errors");
				$finish;
			end
		end
	end

	// preheat: lost boundary, full range of samples, preheat target extremes
	task automatic test_preheat();
		send_sample(-2048, 1'b0);
		send_sample(80, 1'b0);
		send_sample(81, 1'b0);
		send_sample(511, 1'b0);
		send_sample(300, 1'b0);
		drain_results();
		set_reg(CFG_PREHEAT, 2000);
		set_reg(CFG_TRIP, 2047);
		set_reg(CFG_LOST, -880);
		end_writes();
		for (int i = 0; i < 60; i++) send_sample(pick(-2048, 1999), 1'b0);
		drain_results();
		set_reg(CFG_LOST, 2000);
		end_writes();
		for (int i = 0; i < 20; i++) send_sample(pick(-2048, 1999), 1'b0);
		drain_results();
	endtask

	// approach: small and large setpoint, zero band so the window never settles
	task automatic test_approach();
		set_reg(CFG_LOST, -880);
		set_reg(CFG_PREHEAT, 0);
		set_reg(CFG_BAND, 0);
		set_reg(CFG_SETPOINT, 10);
		end_writes();
		send_sample(-879, 1'b0);
		send_sample(-23, 1'b0);
		send_sample(-22, 1'b0);
		for (int i = 0; i < 150; i++) send_sample(pick(-1500, 2047), 1'b0);
		drain_results();
		set_reg(CFG_SETPOINT, 2000);
		end_writes();
		for (int i = 0; i < 150; i++) send_sample(pick(-2048, 2047), 1'b0);
		drain_results();
	endtask

	// settle the window inside the widest band and enter PID
	task automatic test_pid_entry();
		set_reg(CFG_SETPOINT, 592);
		set_reg(CFG_LOST, 80);
		set_reg(CFG_TRIP, 640);
		set_reg(CFG_BAND, 255);
		end_writes();
		send_sample(559, 1'b0);
		send_sample(560, 1'b0);
		send_sample(640, 1'b0);
		for (int i = 0; i < 8; i++) send_sample(600, 1'b0);
		drain_results();
	endtask

	task automatic set_gains(input int p, input int i, input int d);
		set_reg(CFG_GAIN_P, p);
		set_reg(CFG_GAIN_I, i);
		set_reg(CFG_GAIN_D, d);
	endtask

	// PID under a series of gain and setpoint settings
	task automatic test_pid();
		quiet = 1'b1;
		pid_burst(120, 40);
		quiet = 1'b0;
		pid_burst(40, 40);
		drain_results();
		set_gains(0, 0, 0);
		end_writes();
		pid_burst(100, 40);
		drain_results();
		set_gains(65535, 65535, 65535);
		end_writes();
		pid_burst(120, 30);
		drain_results();
		set_gains(0, 1, 0);
		end_writes();
		pid_burst(150, 48);
		drain_results();
		set_gains(pick(0, 2000), 0, pick(0, 65535));
		end_writes();
		pid_burst(150, 48);
		drain_results();
		set_reg(CFG_SETPOINT, 0);
		set_reg(CFG_LOST, -880);
		set_reg(CFG_TRIP, 2047);
		set_gains(7680, 256, 1280);
		end_writes();
		pid_burst(150, 400);
		drain_results();
		set_reg(CFG_SETPOINT, 2000);
		set_reg(CFG_LOST, 80);
		end_writes();
		pid_burst(150, 300);
		drain_results();
		for (int k = 0; k < 4; k++) begin
			set_reg(CFG_SETPOINT, pick(0, 2000));
			set_reg(CFG_LOST, pick(-880, 200));
			set_reg(CFG_TRIP, 2047);
			set_gains(pick(0, 65535), pick(0, 65535), pick(0, 65535));
			end_writes();
			pid_burst(50, pick(4, 600));
			drain_results();
		end
	endtask

	// long receiver hold-off while samples keep coming
	task automatic test_backpressure();
		hold_req = 300;
		pid_burst(8, 30);
		drain_results();
	endtask

	// trip on the out of range flag, then the latched error stage
	task automatic test_trip();
		set_reg(CFG_TRIP, 640);
		end_writes();
		pid_burst(5, 20);
		send_sample(600, 1'b1);
		for (int i = 0; i < 100; i++) send_sample(pick(-2048, 2047), 1'($urandom));
		drain_results();
	endtask

	initial begin
		smp.valid        = 1'b0;
		smp.temperature  = '0;
		smp.out_of_range = 1'b0;
		cfg_we   = 1'b0;
		cfg_idx  = CFG_SETPOINT;
		cfg_data = '0;
		error_count = 0;
		quiet = 1'b0;
		hold_req = 0;
		sp_val = RST_SETPOINT;
		lost_val = int'(RST_LOST);
		trip_val = RST_TRIP;
		preheat_val = RST_PREHEAT;
		band_val = RST_BAND;
		kp = RST_GAIN_P;
		ki = RST_GAIN_I;
		kd = RST_GAIN_D;
		cur_stage = STAGE_PREHEAT;
		foreach (win[i]) win[i] = 0;
		win_pos = 0;
		win_fill = 0;
		integ = 0;
		prev_err = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		test_preheat();
		test_approach();
		test_pid_entry();
		test_pid();
		test_backpressure();
		test_trip();
		drain_results();
		if (error_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
